>>> sv/four_level_alarm_with_deadband_macros.svh
// Assertion macros shared by the alarm block.
// FLAD_ASSERT_IMPL: same-cycle implication; FLAD_ASSERT_NEXT: next-cycle implication.
`ifndef FOUR_LEVEL_ALARM_WITH_DEADBAND_MACROS_SVH
`define FOUR_LEVEL_ALARM_WITH_DEADBAND_MACROS_SVH

`ifndef SYNTH
`define FLAD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("alarm block assertion failed");
`define FLAD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("alarm block assertion failed");
`else
`define FLAD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define FLAD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> sv/flad_pkg.sv
package flad_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned HYST_W = 31;
  localparam int unsigned SEVS_W = 8;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned NUM_LVL = 4;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_UNDEF = 3'd1,
    ST_HIHI  = 3'd2,
    ST_LOLO  = 3'd3,
    ST_HIGH  = 3'd4,
    ST_LOW   = 3'd5
  } alarm_status_t;

  typedef enum logic [1:0] {
    SEV_NONE    = 2'd0,
    SEV_MINOR   = 2'd1,
    SEV_MAJOR   = 2'd2,
    SEV_INVALID = 2'd3
  } alarm_sev_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_HIHI_LIMIT   = 3'd0,
    REG_HIGH_LIMIT   = 3'd1,
    REG_LOW_LIMIT    = 3'd2,
    REG_LOLO_LIMIT   = 3'd3,
    REG_HYSTERESIS   = 3'd4,
    REG_LEVEL_SEVS   = 3'd5,
    REG_VALUE_DBAND  = 3'd6,
    REG_ARCH_DBAND   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] hihi_limit;
    logic signed [DATA_W-1:0] high_limit;
    logic signed [DATA_W-1:0] low_limit;
    logic signed [DATA_W-1:0] lolo_limit;
    logic [HYST_W-1:0]        hysteresis;
    logic [SEVS_W-1:0]        level_severities;
    logic signed [DATA_W-1:0] value_deadband;
    logic signed [DATA_W-1:0] archive_deadband;
  } flad_cfg_t;

endpackage

>>> sv/flad_if.sv
interface flad_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               read_ok;

  modport source (output valid, output sample, output read_ok, input ready);
  modport sink (input valid, input sample, input read_ok, output ready);
endinterface

interface flad_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         alarm_status;
  logic [1:0]         alarm_severity;
  logic               alarm_event;
  logic               value_event;
  logic               archive_event;
  logic signed [31:0] value_out;

  modport source (output valid, output alarm_status, output alarm_severity,
                  output alarm_event, output value_event, output archive_event,
                  output value_out, input ready);
  modport sink (input valid, input alarm_status, input alarm_severity,
                input alarm_event, input value_event, input archive_event,
                input value_out, output ready);
endinterface

>>> sv/flad_cfg.sv
module flad_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [flad_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [flad_pkg::DATA_W-1:0]         cfg_wdata,
  output flad_pkg::flad_cfg_t                 cfg
);
  import flad_pkg::*;

  flad_cfg_t cfg_r;
  flad_cfg_t cfg_nxt;

  // decode the write and drop bits above each register's width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HIHI_LIMIT:  cfg_nxt.hihi_limit       = cfg_wdata;
        REG_HIGH_LIMIT:  cfg_nxt.high_limit       = cfg_wdata;
        REG_LOW_LIMIT:   cfg_nxt.low_limit        = cfg_wdata;
        REG_LOLO_LIMIT:  cfg_nxt.lolo_limit       = cfg_wdata;
        REG_HYSTERESIS:  cfg_nxt.hysteresis       = cfg_wdata[HYST_W-1:0];
        REG_LEVEL_SEVS:  cfg_nxt.level_severities = cfg_wdata[SEVS_W-1:0];
        REG_VALUE_DBAND: cfg_nxt.value_deadband   = cfg_wdata;
        REG_ARCH_DBAND:  cfg_nxt.archive_deadband = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // hold the register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/flad_core.sv
`include "four_level_alarm_with_deadband_macros.svh"

module flad_core (
  input  logic                clk,
  input  logic                rst_n,
  input  flad_pkg::flad_cfg_t cfg,
  flad_in_if.sink             in_ch,
  flad_out_if.source          out_ch
);
  import flad_pkg::*;

  // input register
  logic                     in_vld_r;
  logic signed [DATA_W-1:0] smp_r;
  logic                     rok_r;

  // block state
  logic                     undef_r;
  logic                     undef_nxt;
  logic signed [DATA_W-1:0] lalm_r;
  logic signed [DATA_W-1:0] lalm_nxt;
  logic signed [DATA_W-1:0] lval_r;
  logic signed [DATA_W-1:0] larc_r;
  alarm_status_t            prev_st_r;
  alarm_sev_t               prev_sev_r;

  // result register
  logic                     out_vld_r;
  alarm_status_t            st_r;
  alarm_sev_t               sev_r;
  logic                     aev_r;
  logic                     vev_r;
  logic                     arev_r;
  logic signed [DATA_W-1:0] vout_r;

  // stage logic
  logic                     advance;
  alarm_status_t            st_nxt;
  alarm_sev_t               sev_nxt;
  logic                     aev_nxt;
  logic                     vev_nxt;
  logic                     arev_nxt;
  logic signed [DATA_W:0]   val_x;
  logic signed [DATA_W:0]   lalm_x;
  logic signed [DATA_W:0]   hyst_x;
  logic signed [DATA_W:0]   lev_x [NUM_LVL];
  logic signed [DATA_W-1:0] lims [NUM_LVL];
  logic [1:0]               lsev [NUM_LVL];
  logic [NUM_LVL-1:0]       hit;

  localparam alarm_status_t LVL_STATUS [NUM_LVL] = '{ST_HIHI, ST_LOLO, ST_HIGH, ST_LOW};

  // absolute change against a posted value, or always when the band is negative
  function automatic logic db_pass(input logic signed [DATA_W-1:0] last,
                                   input logic signed [DATA_W-1:0] val,
                                   input logic signed [DATA_W-1:0] band);
    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]        mag;
    diff = {last[DATA_W-1], last} - {val[DATA_W-1], val};
    mag  = diff[DATA_W] ? -diff : diff;
    return band[DATA_W-1] || (mag[DATA_W-1:0] > band[DATA_W-1:0]);
  endfunction

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      smp_r <= in_ch.sample;
      rok_r <= in_ch.read_ok;
    end
  end

  // level checks, all four side by side
  always_comb begin
    lims[0] = cfg.hihi_limit;
    lims[1] = cfg.lolo_limit;
    lims[2] = cfg.high_limit;
    lims[3] = cfg.low_limit;
    val_x   = {smp_r[DATA_W-1], smp_r};
    lalm_x  = {lalm_r[DATA_W-1], lalm_r};
    hyst_x  = {2'b00, cfg.hysteresis};
    for (int k = 0; k < NUM_LVL; k++) begin
      lsev[k]  = cfg.level_severities[2*k +: 2];
      lev_x[k] = {lims[k][DATA_W-1], lims[k]};
      if ((k % 2) == 0) begin
        hit[k] = (lsev[k] != 2'd0) &&
                 ((val_x >= lev_x[k]) ||
                  ((lalm_x == lev_x[k]) && (val_x >= lev_x[k] - hyst_x)));
      end else begin
        hit[k] = (lsev[k] != 2'd0) &&
                 ((val_x <= lev_x[k]) ||
                  ((lalm_x == lev_x[k]) && (val_x <= lev_x[k] + hyst_x)));
      end
    end
  end

  // pick the first matching level and form the result word
  always_comb begin
    undef_nxt = undef_r && !rok_r;
    st_nxt    = ST_NONE;
    sev_nxt   = SEV_NONE;
    lalm_nxt  = lalm_r;
    if (undef_nxt) begin
      st_nxt  = ST_UNDEF;
      sev_nxt = SEV_INVALID;
    end else begin
      lalm_nxt = smp_r;
      for (int k = NUM_LVL - 1; k >= 0; k--) begin
        if (hit[k]) begin
          st_nxt   = LVL_STATUS[k];
          sev_nxt  = alarm_sev_t'(lsev[k]);
          lalm_nxt = lims[k];
        end
      end
    end
    aev_nxt  = (st_nxt != prev_st_r) || (sev_nxt != prev_sev_r);
    vev_nxt  = db_pass(lval_r, smp_r, cfg.value_deadband);
    arev_nxt = db_pass(larc_r, smp_r, cfg.archive_deadband);
  end

  // advance state on each word that leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undef_r    <= 1'b1;
      lalm_r     <= '0;
      lval_r     <= '0;
      larc_r     <= '0;
      prev_st_r  <= ST_NONE;
      prev_sev_r <= SEV_NONE;
    end else if (advance) begin
      undef_r    <= undef_nxt;
      lalm_r     <= lalm_nxt;
      prev_st_r  <= st_nxt;
      prev_sev_r <= sev_nxt;
      if (vev_nxt) begin
        lval_r <= smp_r;
      end
      if (arev_nxt) begin
        larc_r <= smp_r;
      end
    end
  end

  // result register: fill on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_r   <= st_nxt;
      sev_r  <= sev_nxt;
      aev_r  <= aev_nxt;
      vev_r  <= vev_nxt;
      arev_r <= arev_nxt;
      vout_r <= smp_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.alarm_status   = st_r;
  assign out_ch.alarm_severity = sev_r;
  assign out_ch.alarm_event    = aev_r;
  assign out_ch.value_event    = vev_r;
  assign out_ch.archive_event  = arev_r;
  assign out_ch.value_out      = vout_r;

  `FLAD_ASSERT_IMPL(a_undef_invalid, clk, rst_n, out_vld_r && st_r == ST_UNDEF, sev_r == SEV_INVALID)
  `FLAD_ASSERT_IMPL(a_none_sev, clk, rst_n, out_vld_r && st_r == ST_NONE, sev_r == SEV_NONE)
  `FLAD_ASSERT_IMPL(a_level_sev, clk, rst_n, out_vld_r && st_r != ST_NONE && st_r != ST_UNDEF, sev_r != SEV_NONE)
  `FLAD_ASSERT_NEXT(a_undef_sticky, clk, rst_n, !undef_r, !undef_r)
  `FLAD_ASSERT_NEXT(a_state_mirror, clk, rst_n, advance, prev_st_r == st_r && prev_sev_r == sev_r)

endmodule

>>> sv/four_level_alarm_with_deadband.sv
// Channel   Dir  Word contents
// --------  ---  ---------------------------------------------------------
// in_ch     in   sample (signed 32), read_ok
// out_ch    out  alarm_status, alarm_severity, alarm/value/archive events, value_out
// cfg_*     in   write enable, 3-bit register index, 32-bit write data
//
// One word per cycle sustained while out_ch.ready holds; a taken word passes the input register,
// then the level checks and deadband compares into the result register.
// Synchronous active-low reset clears all settings to zero and sets the undefined flag.
// A stalled output holds the result register; the input register still takes one word,
// then in_ch.ready drops until the result is taken.
module four_level_alarm_with_deadband (
  input  logic                        clk,
  input  logic                        rst_n,
  flad_in_if.sink                     in_ch,
  flad_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [flad_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [flad_pkg::DATA_W-1:0] cfg_wdata
);
  import flad_pkg::*;

  flad_cfg_t cfg;

  // settings
  flad_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // alarm evaluation pipeline
  flad_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> dv/tb_four_level_alarm_with_deadband.sv
module tb_four_level_alarm_with_deadband;
  import flad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    alarm_status_t      status;
    alarm_sev_t         sev;
    logic               alarm_ev;
    logic               value_ev;
    logic               archive_ev;
    logic signed [31:0] value;
  } alarm_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_addr;
  logic [31:0] cfg_wdata;

  flad_in_if  in_ch();
  flad_out_if out_ch();

  four_level_alarm_with_deadband i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Register mirror, updated on each write
  logic signed [31:0] lim_hihi = '0, lim_high = '0, lim_low = '0, lim_lolo = '0;
  logic [30:0]        hyst_margin = '0;
  logic [7:0]         level_sevs = '0;
  logic signed [31:0] val_band = '0, arch_band = '0;

  // Alarm state mirror
  logic               still_undef = 1'b1;
  logic signed [31:0] last_level = '0, last_val_post = '0, last_arch_post = '0;
  alarm_status_t      prev_status = ST_NONE;
  alarm_sev_t         prev_sev = SEV_NONE;

  alarm_word_t alarm_expect_q[$];
  logic [31:0] reg_words [8];
  int          mismatch_cnt = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0, hold_ack = 1'b0;
  int          hold_left = 0;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Absolute change since the last post, or always when the band is negative
  function automatic bit band_passed(logic signed [31:0] last, logic signed [31:0] s,
                                     logic signed [31:0] band);
    longint d;
    if (band < 0) return 1'b1;
    d = longint'(last) - longint'(s);
    if (d < 0) d = -d;
    return d > longint'(band);
  endfunction

  // Advance the alarm state by one sample and return the word it should produce
  function automatic alarm_word_t predict_alarm(logic signed [31:0] s, logic ok);
    alarm_word_t        w;
    alarm_status_t      codes [4];
    logic signed [31:0] lims [4];
    longint             v, lalm, hy, lv;
    bit                 hit, m;
    alarm_sev_t         sk;
    codes = '{ST_HIHI, ST_LOLO, ST_HIGH, ST_LOW};
    lims  = '{lim_hihi, lim_lolo, lim_high, lim_low};
    v    = longint'(s);
    lalm = longint'(last_level);
    hy   = longint'(hyst_margin);
    w.status = ST_NONE;
    w.sev    = SEV_NONE;
    if (ok) still_undef = 1'b0;
    if (still_undef) begin
      w.status = ST_UNDEF;
      w.sev    = SEV_INVALID;
    end else begin
      hit = 1'b0;
      for (int k = 0; k < NUM_LVL; k++) begin
        sk = alarm_sev_t'(level_sevs[2*k +: 2]);
        lv = longint'(lims[k]);
        if (!hit && sk != SEV_NONE) begin
          // even slots are the upper checks
          if (k % 2 == 0) m = (v >= lv) || (lalm == lv && v >= lv - hy);
          else            m = (v <= lv) || (lalm == lv && v <= lv + hy);
          if (m) begin
            hit        = 1'b1;
            w.status   = codes[k];
            w.sev      = sk;
            last_level = lims[k];
          end
        end
      end
      if (!hit) last_level = s;
    end
    w.alarm_ev  = (w.status != prev_status) || (w.sev != prev_sev);
    prev_status = w.status;
    prev_sev    = w.sev;
    w.value_ev  = band_passed(last_val_post, s, val_band);
    if (w.value_ev) last_val_post = s;
    w.archive_ev = band_passed(last_arch_post, s, arch_band);
    if (w.archive_ev) last_arch_post = s;
    w.value = s;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Watch the write port and both channels
  always @(posedge clk) begin
    alarm_word_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (alarm_expect_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          e = alarm_expect_q.pop_front();
          if (out_ch.alarm_status !== e.status)
            report_mismatch($sformatf("alarm_status got %0d want %0d",
                                      out_ch.alarm_status, e.status));
          if (out_ch.alarm_severity !== e.sev)
            report_mismatch($sformatf("alarm_severity got %0d want %0d",
                                      out_ch.alarm_severity, e.sev));
          if (out_ch.alarm_event !== e.alarm_ev)
            report_mismatch($sformatf("alarm_event got %b want %b",
                                      out_ch.alarm_event, e.alarm_ev));
          if (out_ch.value_event !== e.value_ev)
            report_mismatch($sformatf("value_event got %b want %b",
                                      out_ch.value_event, e.value_ev));
          if (out_ch.archive_event !== e.archive_ev)
            report_mismatch($sformatf("archive_event got %b want %b",
                                      out_ch.archive_event, e.archive_ev));
          if (out_ch.value_out !== e.value)
            report_mismatch($sformatf("value_out got %0d want %0d",
                                      out_ch.value_out, e.value));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_HIHI_LIMIT:  lim_hihi    = cfg_wdata;
          REG_HIGH_LIMIT:  lim_high    = cfg_wdata;
          REG_LOW_LIMIT:   lim_low     = cfg_wdata;
          REG_LOLO_LIMIT:  lim_lolo    = cfg_wdata;
          REG_HYSTERESIS:  hyst_margin = cfg_wdata[30:0];
          REG_LEVEL_SEVS:  level_sevs  = cfg_wdata[7:0];
          REG_VALUE_DBAND: val_band    = cfg_wdata;
          REG_ARCH_DBAND:  arch_band   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        alarm_expect_q.push_back(predict_alarm(in_ch.sample, in_ch.read_ok));
    end
  end

  // Result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word, leave valid high once it is taken
  task automatic send_word(logic signed [31:0] s, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.read_ok <= ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every expected word is back
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (alarm_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers from reg_words, block idle
  task automatic load_settings();
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= r;
      cfg_wdata <= reg_words[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_band();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(20);
      3:       return 32'h7FFF_FFFF;
      4:       return {1'b1, 31'($urandom)};
      default: return $urandom_range(500);
    endcase
  endfunction

  task automatic pick_random_settings();
    logic signed [31:0] c, span;
    logic [30:0]        hy;
    c    = $urandom_range(4000) - 2000;
    span = $urandom_range(1, 200);
    case ($urandom_range(5))
      0, 1, 2: begin
        reg_words[REG_HIHI_LIMIT] = c + 2 * span;
        reg_words[REG_HIGH_LIMIT] = c + span;
        reg_words[REG_LOW_LIMIT]  = c - span;
        reg_words[REG_LOLO_LIMIT] = c - 2 * span;
      end
      3: begin
        // overlapping or inverted limits near one point
        reg_words[REG_HIHI_LIMIT] = c + $urandom_range(400) - 200;
        reg_words[REG_HIGH_LIMIT] = c + $urandom_range(400) - 200;
        reg_words[REG_LOW_LIMIT]  = c + $urandom_range(400) - 200;
        reg_words[REG_LOLO_LIMIT] = c + $urandom_range(400) - 200;
      end
      4: begin
        reg_words[REG_HIHI_LIMIT] = $urandom;
        reg_words[REG_HIGH_LIMIT] = $urandom;
        reg_words[REG_LOW_LIMIT]  = $urandom;
        reg_words[REG_LOLO_LIMIT] = $urandom;
      end
      default: begin
        reg_words[REG_HIHI_LIMIT] = 32'h7FFF_FFFF;
        reg_words[REG_HIGH_LIMIT] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'd0;
        reg_words[REG_LOW_LIMIT]  = $urandom_range(1) ? 32'h8000_0000 : 32'd0;
        reg_words[REG_LOLO_LIMIT] = 32'h8000_0000;
      end
    endcase
    case ($urandom_range(4))
      0:       hy = '0;
      1:       hy = 31'h7FFF_FFFF;
      2:       hy = 31'($urandom);
      default: hy = 31'($urandom_range(2 * span));
    endcase
    // top bit of the hysteresis write and upper severity bits get dropped
    reg_words[REG_HYSTERESIS]  = {1'($urandom_range(1)), hy};
    reg_words[REG_LEVEL_SEVS]  = $urandom;
    reg_words[REG_VALUE_DBAND] = pick_band();
    reg_words[REG_ARCH_DBAND]  = pick_band();
    load_settings();
  endtask

  // Samples cluster around the limits and the hysteresis edges, with some random and extreme values
  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] lims [4];
    logic signed [31:0] lim;
    int                 reach;
    lims  = '{lim_hihi, lim_high, lim_low, lim_lolo};
    lim   = lims[$urandom_range(3)];
    reach = (hyst_margin > 64) ? 64 : int'(hyst_margin);
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: return lim - $signed({1'b0, hyst_margin}) + $urandom_range(2) - 1;
      3: return lim + $signed({1'b0, hyst_margin}) + $urandom_range(2) - 1;
      default: return lim + $urandom_range(2 * reach + 6) - (reach + 3);
    endcase
  endfunction

  task automatic test_undefined_start();
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'sd5, 1'b1);
    send_word(32'sd0, 1'b0);
    wait_results_done();
  endtask

  task automatic test_level_order_and_hysteresis();
    logic signed [31:0] pts [];
    pts = '{0, 100, 95, 89, 45, 39, -50, -100, -91, -89, 0, 32'h7FFF_FFFF, 32'h8000_0000, 3};
    reg_words[REG_HIHI_LIMIT]  = 32'sd100;
    reg_words[REG_HIGH_LIMIT]  = 32'sd50;
    reg_words[REG_LOW_LIMIT]   = -32'sd50;
    reg_words[REG_LOLO_LIMIT]  = -32'sd100;
    reg_words[REG_HYSTERESIS]  = 32'd10;
    // low invalid, high minor, lolo major, hihi major
    reg_words[REG_LEVEL_SEVS]  = 32'({SEV_INVALID, SEV_MINOR, SEV_MAJOR, SEV_MAJOR});
    reg_words[REG_VALUE_DBAND] = 32'd5;
    reg_words[REG_ARCH_DBAND]  = 32'hFFFF_FFFF;
    load_settings();
    foreach (pts[i]) send_word(pts[i], (i != 10));
    wait_results_done();
  endtask

  task automatic test_extreme_limits();
    reg_words[REG_HIHI_LIMIT]  = 32'h7FFF_FFFF;
    reg_words[REG_HIGH_LIMIT]  = 32'd0;
    reg_words[REG_LOW_LIMIT]   = 32'd0;
    reg_words[REG_LOLO_LIMIT]  = 32'h8000_0000;
    reg_words[REG_HYSTERESIS]  = 32'hFFFF_FFFF;
    reg_words[REG_LEVEL_SEVS]  = 32'hFFFF_FF55;
    reg_words[REG_VALUE_DBAND] = 32'h7FFF_FFFF;
    reg_words[REG_ARCH_DBAND]  = 32'd0;
    load_settings();
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'd0, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_traffic(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct    <= stall;
    pick_random_settings();
    repeat (n) send_word(pick_sample(), ($urandom_range(9) != 0));
    wait_results_done();
  endtask

  // Long result hold-off while the sender keeps offering
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    stall_pct    <= 0;
    pick_random_settings();
    hold_req <= ~hold_req;
    repeat (40) send_word(pick_sample(), 1'b1);
    wait_results_done();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_HIHI_LIMIT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.read_ok = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_undefined_start();
    test_level_order_and_hysteresis();
    test_extreme_limits();
    repeat (2) begin
      test_random_traffic(75, 0, 0);
      test_random_traffic(75, 61, 0);
      test_random_traffic(75, 0, 61);
      test_random_traffic(75, 30, 30);
    end
    test_backpressure_fill();
    test_random_traffic(40, 30, 30);

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> four_level_alarm_with_deadband.f
+incdir+sv
sv/flad_pkg.sv
sv/flad_if.sv
sv/flad_cfg.sv
sv/flad_core.sv
sv/four_level_alarm_with_deadband.sv
dv/tb_four_level_alarm_with_deadband.sv
